>>> src/zdst_pkg.sv
// Shared constants, zone table and helper functions for the zoned disc sector tracker.
package zdst_pkg;

   localparam int SECTOR_W = 20;
   localparam int ZONE_W   = 4;
   localparam int COUNT_W  = 16;
   localparam int SPT_W    = 5;
   localparam int WANT_W   = SECTOR_W + 1;
   localparam int SUM_W    = SECTOR_W + 2;

   localparam int ZONE_COUNT = 16;
   localparam logic [ZONE_W-1:0] LAST_ZONE = ZONE_W'(ZONE_COUNT - 1);
   localparam int TBL_DEPTH = 15;

   localparam logic [SECTOR_W-1:0] DISC_END         = SECTOR_W'(999999);
   localparam logic [SECTOR_W-1:0] MAX_SECTOR_RESET = SECTOR_W'(337500);
   localparam logic [SPT_W-1:0]    SPT_BASE         = SPT_W'(8);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   // upper sector boundary of zones 0..14
   localparam logic [SECTOR_W-1:0] ZONE_END_TBL [0:TBL_DEPTH-1] = '{
      SECTOR_W'(4500),   SECTOR_W'(7750),   SECTOR_W'(13500),  SECTOR_W'(27000),
      SECTOR_W'(45000),  SECTOR_W'(63000),  SECTOR_W'(85500),  SECTOR_W'(103500),
      SECTOR_W'(130500), SECTOR_W'(153000), SECTOR_W'(175500), SECTOR_W'(207000),
      SECTOR_W'(234000), SECTOR_W'(265500), SECTOR_W'(297000)
   };

   // the last zone and anything at or past table depth run to the end of the disc
   function automatic logic [SECTOR_W-1:0] zone_end(input logic [ZONE_W-1:0] z);
      logic [SECTOR_W-1:0] e;
      begin
         if (z >= LAST_ZONE || z >= ZONE_W'(TBL_DEPTH)) begin
            e = DISC_END;
         end else begin
            e = ZONE_END_TBL[z];
         end
         return e;
      end
   endfunction

   function automatic logic [SPT_W-1:0] zone_spt(input logic [ZONE_W-1:0] z);
      return SPT_BASE + SPT_W'(z);
   endfunction

endpackage

>>> src/zoned_disc_sector_tracker.sv
// Zoned disc sector tracker: head position, zone stepping and track jumps.
//
// Tracks the read-head sector and zone of an emulated optical disc. An advance
// item (tuser = 0) goes from accept straight to the result state. A jump item
// (tuser = 1) walks the disc zone by zone; each zone visited goes from setup
// straight to apply when the whole remaining request fits in the zone and passes
// through the divide state when it does not, because the sectors left in the zone
// are then divided by the zone's sectors-per-track in a shared restoring divider
// that retires one quotient bit per cycle (16 bits). A jump with a zero count
// goes straight to the result state. req_tready is high only while the tracker
// is idle; a finished result waits in an output register, so the next item can
// be taken before the previous result is accepted. max_sector is written on the
// csr channel, which is ready only while the tracker is idle.
module zoned_disc_sector_tracker
   import zdst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // tdata: [15:0] track_count, [16] reverse, rest zero
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: [0] mode (0 advance, 1 jump)
   input  logic                  req_tuser,
   // tdata: [19:0] sector, [23:20] zone_index, [24] servo_ok, [44:25] jump_target
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: [0] halt_audio
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SECTOR_W-1:0]   csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_APPLY = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [SECTOR_W-1:0]   max_sector_ff, max_sector_in;
   logic [SECTOR_W-1:0]   head_ff, head_in;
   logic [ZONE_W-1:0]     zone_ff, zone_in;
   logic [SECTOR_W-1:0]   last_jump_ff, last_jump_in;
   logic                  mode_ff, mode_in;
   logic                  rev_ff, rev_in;
   logic [COUNT_W-1:0]    step_ff, step_in;
   logic [SPT_W-1:0]      spt_ff, spt_in;
   logic [SECTOR_W-1:0]   left_ff, left_in;
   logic [COUNT_W-1:0]    tracks_ff, tracks_in;
   logic [WANT_W-1:0]     adv_ff, adv_in;
   logic [SPT_W-1:0]      div_rem_ff, div_rem_in;
   logic [COUNT_W-1:0]    div_quo_ff, div_quo_in;
   logic [3:0]            div_cnt_ff, div_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   // setup and datapath terms
   logic [SPT_W-1:0]      spt_s;
   logic [WANT_W-1:0]     want_s;
   logic [SECTOR_W-1:0]   fwd_end_s, prev_end_s, left_s, adv_head_s, jt_s;
   logic                  wrap_s, big_s, div_ge_s;
   logic [SPT_W:0]        div_trial_s;
   logic [SPT_W-1:0]      div_rem_s;
   logic [COUNT_W-1:0]    div_quo_s, step_rem_s, req_count_s;
   logic [SUM_W-1:0]      sum_s;
   logic [ZONE_W-1:0]     clamp_zone_s;
   logic                  idle_s;

   assign idle_s      = (state_ff == ST_IDLE);
   assign req_tready  = idle_s;
   assign csr_ready   = idle_s;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;
   assign rsp_tuser   = rsp_user_ff;
   assign req_count_s = req_tdata[COUNT_W-1:0];

   // zone just below the first one whose boundary passes max_sector
   always_comb begin
      clamp_zone_s = LAST_ZONE;
      for (int z = ZONE_COUNT - 1; z >= 0; z--) begin
         if (zone_end(ZONE_W'(z)) > max_sector_ff) begin
            clamp_zone_s = (z == 0) ? '0 : ZONE_W'(z - 1);
         end
      end
   end

   assign spt_s      = zone_spt(zone_ff);
   assign want_s     = WANT_W'(step_ff) * WANT_W'(spt_s);
   assign fwd_end_s  = zone_end(zone_ff);
   assign prev_end_s = zone_end(zone_ff - ZONE_W'(1));

   // a head already past the boundary, or a reverse step in zone 0, gives a wrapped, effectively endless span
   always_comb begin
      if (!rev_ff) begin
         wrap_s = head_ff > fwd_end_s;
         left_s = fwd_end_s - head_ff;
      end else begin
         wrap_s = (zone_ff == '0) || (head_ff < prev_end_s);
         left_s = head_ff - prev_end_s;
      end
   end
   assign big_s = wrap_s || (WANT_W'(left_s) >= want_s);

   // shared divider: one quotient bit a cycle
   assign div_trial_s = {div_rem_ff, div_quo_ff[COUNT_W-1]};
   assign div_ge_s    = div_trial_s >= (SPT_W + 1)'(spt_ff);
   assign div_rem_s   = div_ge_s ? SPT_W'(div_trial_s - (SPT_W + 1)'(spt_ff))
                                 : div_trial_s[SPT_W-1:0];
   assign div_quo_s   = {div_quo_ff[COUNT_W-2:0], div_ge_s};

   assign sum_s       = SUM_W'(head_ff) + SUM_W'(adv_ff);
   assign step_rem_s  = step_ff - tracks_ff;
   assign adv_head_s  = (head_ff < max_sector_ff) ? head_ff + SECTOR_W'(1) : head_ff;
   assign jt_s        = mode_ff ? head_ff : last_jump_ff;

   always_comb begin
      state_in      = state_ff;
      max_sector_in = max_sector_ff;
      head_in       = head_ff;
      zone_in       = zone_ff;
      last_jump_in  = last_jump_ff;
      mode_in       = mode_ff;
      rev_in        = rev_ff;
      step_in       = step_ff;
      spt_in        = spt_ff;
      left_in       = left_ff;
      tracks_in     = tracks_ff;
      adv_in        = adv_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      if (csr_valid && csr_ready) begin
         max_sector_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               rev_in  = req_tdata[COUNT_W];
               step_in = req_count_s;
               if (!req_tuser) begin
                  head_in = adv_head_s;
                  if (adv_head_s > zone_end(zone_ff) && zone_ff != LAST_ZONE) begin
                     zone_in = zone_ff + ZONE_W'(1);
                  end
                  state_in = ST_DONE;
               end else if (req_count_s == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            spt_in  = spt_s;
            left_in = left_s;
            if (big_s) begin
               tracks_in = step_ff;
               adv_in    = want_s;
               state_in  = ST_APPLY;
            end else begin
               // left < step * spt, so the top bits are already below spt
               div_rem_in = SPT_W'(left_s[SECTOR_W-1:COUNT_W]);
               div_quo_in = left_s[COUNT_W-1:0];
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            div_rem_in = div_rem_s;
            div_quo_in = div_quo_s;
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'd15) begin
               tracks_in = div_quo_s;
               adv_in    = WANT_W'(left_ff) - WANT_W'(div_rem_s);
               state_in  = ST_APPLY;
            end
         end
         ST_APPLY: begin
            step_in = step_rem_s;
            if (!rev_ff) begin
               if (sum_s > SUM_W'(max_sector_ff)) begin
                  head_in  = max_sector_ff;
                  zone_in  = clamp_zone_s;
                  state_in = ST_DONE;
               end else begin
                  head_in = sum_s[SECTOR_W-1:0];
                  if (step_rem_s == '0 || zone_ff == LAST_ZONE) begin
                     state_in = ST_DONE;
                  end else begin
                     zone_in  = zone_ff + ZONE_W'(1);
                     state_in = ST_SETUP;
                  end
               end
            end else begin
               if (WANT_W'(head_ff) > adv_ff) begin
                  head_in = head_ff - adv_ff[SECTOR_W-1:0];
                  if (step_rem_s == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     if (zone_ff != '0) begin
                        zone_in = zone_ff - ZONE_W'(1);
                     end
                     state_in = ST_SETUP;
                  end
               end else begin
                  head_in  = '0;
                  zone_in  = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = mode_ff;
               rsp_data_in  = RSP_DATA_W'({jt_s, (head_ff < max_sector_ff), zone_ff, head_ff});
               last_jump_in = jt_s;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         max_sector_ff <= MAX_SECTOR_RESET;
         head_ff       <= '0;
         zone_ff       <= '0;
         last_jump_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_sector_ff <= max_sector_in;
         head_ff       <= head_in;
         zone_ff       <= zone_in;
         last_jump_ff  <= last_jump_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      rev_ff      <= rev_in;
      step_ff     <= step_in;
      spt_ff      <= spt_in;
      left_ff     <= left_in;
      tracks_ff   <= tracks_in;
      adv_ff      <= adv_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // divider partial remainder always stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_rem_ff < spt_ff))
      else $error("divider remainder reached divisor");

   // an advance item goes straight to result
   a_adv_done: assert property (@(posedge clock) disable iff (reset)
      (idle_s && req_tvalid && !req_tuser) |=> (state_ff == ST_DONE))
      else $error("advance item did not finish in one step");

   // a forward step never leaves the head beyond max_sector
   a_fwd_clamp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && !rev_ff) |=> (head_ff <= max_sector_ff))
      else $error("forward jump passed max_sector");

   // reverse underflow lands on sector 0, zone 0
   a_rev_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && rev_ff && (WANT_W'(head_ff) <= adv_ff))
      |=> (head_ff == '0 && zone_ff == '0))
      else $error("reverse underflow not clamped to origin");

   // a jump result reports its own sector as the jump target
   a_jump_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff)
      |-> (rsp_data_ff[SECTOR_W-1:0] == rsp_data_ff[2*SECTOR_W+ZONE_W:SECTOR_W+ZONE_W+1]))
      else $error("jump target differs from sector");

endmodule
